// File: rtl/core/static_lcd_segment_driver_unit_assert.svh
// assertion macros for the static lcd segment driver
`ifndef STATIC_LCD_SEGMENT_DRIVER_UNIT_ASSERT_SVH
`define STATIC_LCD_SEGMENT_DRIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define SLCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SLCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/slcd_pkg.sv
`default_nettype none
package slcd_pkg;

  localparam int NUM_POS = 16;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [1:0] OP_DIGIT = 2'd0;
  localparam logic [1:0] OP_DOT   = 2'd1;
  localparam logic [1:0] OP_COLON = 2'd2;
  localparam logic [1:0] OP_FRAME = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] digit_index;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic line_zero;
    logic line_one;
    logic line_two;
    logic common_level;
    logic drive_enable;
    logic last;
  } out_res_t;

  // one bit of the segment map: shift position and data line
  typedef struct packed {
    logic [3:0] pos;
    logic [1:0] line;
  } seg_loc_t;

  typedef logic [NUM_POS-1:0][2:0] seg_map_t;

  // controller to datapath
  typedef struct packed {
    logic apply_cmd;
    logic start_frame;
    logic emit;
  } slcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic at_latch;
  } slcd_sts_t;

  // segments a..g of digits 1..6
  localparam seg_loc_t DIGIT_LOC [6][7] = '{
    '{'{4'd2, 2'd2},  '{4'd3, 2'd2},  '{4'd13, 2'd0}, '{4'd14, 2'd0},
      '{4'd15, 2'd0}, '{4'd1, 2'd2},  '{4'd0, 2'd2}},
    '{'{4'd6, 2'd2},  '{4'd7, 2'd2},  '{4'd9, 2'd0},  '{4'd10, 2'd0},
      '{4'd11, 2'd0}, '{4'd5, 2'd2},  '{4'd4, 2'd2}},
    '{'{4'd10, 2'd2}, '{4'd11, 2'd2}, '{4'd5, 2'd0},  '{4'd6, 2'd0},
      '{4'd7, 2'd0},  '{4'd9, 2'd2},  '{4'd8, 2'd2}},
    '{'{4'd14, 2'd2}, '{4'd15, 2'd2}, '{4'd1, 2'd0},  '{4'd2, 2'd0},
      '{4'd3, 2'd0},  '{4'd13, 2'd2}, '{4'd12, 2'd2}},
    '{'{4'd3, 2'd1},  '{4'd4, 2'd1},  '{4'd13, 2'd1}, '{4'd14, 2'd1},
      '{4'd15, 2'd1}, '{4'd2, 2'd1},  '{4'd1, 2'd1}},
    '{'{4'd7, 2'd1},  '{4'd8, 2'd1},  '{4'd9, 2'd1},  '{4'd10, 2'd1},
      '{4'd11, 2'd1}, '{4'd6, 2'd1},  '{4'd5, 2'd1}}
  };

  // decimal dots 1..5
  localparam seg_loc_t DOT_LOC [5] = '{
    '{4'd12, 2'd0}, '{4'd8, 2'd0}, '{4'd4, 2'd0}, '{4'd0, 2'd0}, '{4'd12, 2'd1}
  };

  localparam seg_loc_t COLON_LOC = '{4'd0, 2'd1};

  // patterns gfedcba for '0'..'9'
  localparam logic [6:0] NUMERAL_PAT [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  function automatic logic [6:0] char_to_seg(input logic [7:0] c);
    logic [7:0] ofs;
    ofs = c - CHAR_ZERO;
    if (c == CHAR_SPACE) begin
      char_to_seg = 7'h00;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      char_to_seg = NUMERAL_PAT[ofs[3:0]];
    end else begin
      char_to_seg = 7'h7f;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/slcd_ctrl.sv
`default_nettype none
`include "static_lcd_segment_driver_unit_assert.svh"
module slcd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_opcode,
  output logic                     in_stall,
  input  wire slcd_pkg::slcd_sts_t sts,
  output slcd_pkg::slcd_cmd_t      cmd
);
  import slcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt       = state_r;
    cmd.apply_cmd   = 1'b0;
    cmd.start_frame = 1'b0;
    cmd.emit        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_FRAME) begin
            cmd.start_frame = 1'b1;
            state_nxt       = ST_SEND;
          end else begin
            cmd.apply_cmd = 1'b1;
          end
        end
      end
      ST_SEND: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.at_latch) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SLCD_ASSERT(a_frame_enters_send, clk, rst_n, cmd.start_frame |=> state_r == ST_SEND, "frame request did not start serializing")
  `SLCD_ASSERT(a_latch_ends_send, clk, rst_n, (cmd.emit && sts.at_latch) |=> state_r == ST_IDLE, "serializer did not return to idle after latch")
  `SLCD_ASSERT(a_no_emit_when_idle, clk, rst_n, (state_r == ST_IDLE) |-> !cmd.emit, "result emitted outside a frame")

endmodule
`default_nettype wire

// File: rtl/core/slcd_dp.sv
`default_nettype none
`include "static_lcd_segment_driver_unit_assert.svh"
module slcd_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slcd_pkg::in_req_t   in_req,
  input  wire slcd_pkg::slcd_cmd_t cmd,
  output slcd_pkg::slcd_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slcd_pkg::out_res_t       out_res
);
  import slcd_pkg::*;

  seg_map_t           map_r, map_nxt;
  logic               phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_data_r, out_data_nxt;
  logic [6:0]         seg;
  logic [2:0]         idx_m1;
  logic [2:0]         pos_data;
  seg_loc_t           loc;

  assign seg    = char_to_seg(in_req.char_code);
  assign idx_m1 = in_req.digit_index - 3'd1;

  // map update for digit, dot and colon requests
  always_comb begin
    map_nxt = map_r;
    loc     = COLON_LOC;
    if (cmd.apply_cmd) begin
      unique case (in_req.opcode)
        OP_DIGIT: begin
          if (in_req.digit_index >= 3'd1 && in_req.digit_index <= 3'd6) begin
            for (int k = 0; k < 7; k++) begin
              map_nxt[DIGIT_LOC[idx_m1][k].pos][DIGIT_LOC[idx_m1][k].line] = seg[k];
            end
          end
        end
        OP_DOT: begin
          if (in_req.digit_index >= 3'd1 && in_req.digit_index <= 3'd5) begin
            loc = DOT_LOC[idx_m1];
            map_nxt[loc.pos][loc.line] = in_req.char_code[0];
          end
        end
        OP_COLON: begin
          map_nxt[COLON_LOC.pos][COLON_LOC.line] = in_req.char_code[0];
        end
        default: begin
          map_nxt = map_r;
        end
      endcase
    end
  end

  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.at_latch  = cnt_r[CNT_W-1];

  assign pos_data = phase_r ? map_r[cnt_r[POS_W-1:0]] : ~map_r[cnt_r[POS_W-1:0]];

  always_comb begin
    phase_nxt     = cmd.start_frame ? ~phase_r : phase_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.start_frame) begin
      cnt_nxt = '0;
    end else if (cmd.emit) begin
      // counter stops at the latch step
      cnt_nxt       = sts.at_latch ? cnt_r : cnt_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
      if (sts.at_latch) begin
        out_data_nxt = '{line_zero: 1'b0, line_one: 1'b0, line_two: 1'b0,
                         common_level: ~phase_r, drive_enable: 1'b1, last: 1'b1};
      end else begin
        out_data_nxt = '{line_zero: pos_data[0], line_one: pos_data[1],
                         line_two: pos_data[2], common_level: 1'b0,
                         drive_enable: 1'b0, last: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '1;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  `SLCD_ASSERT(a_latch_marks_last, clk, rst_n, (cmd.emit && sts.at_latch) |=> (out_valid_r && out_data_r.last && out_data_r.drive_enable), "latch result not marked last")
  `SLCD_ASSERT(a_frame_flips_phase, clk, rst_n, cmd.start_frame |=> (phase_r != $past(phase_r) && cnt_r == '0), "frame start did not flip phase or clear position")
  `SLCD_ASSERT_ALWAYS(a_cnt_in_range, clk, !rst_n || cnt_r <= CNT_W'(NUM_POS), "position counter past latch step")

endmodule
`default_nettype wire

// File: rtl/core/static_lcd_segment_driver_unit.sv
`default_nettype none
// channel   direction  handshake           payload
// in_       request    in_valid/in_stall   in_req   (opcode, digit_index, char_code)
// out_      result     out_valid/out_stall out_res  (three data lines, com, enable, last)
//
// digit, dot and colon requests are applied to the segment map when accepted and produce no result
// a frame request produces 16 data results then one latch result, one per cycle
// when out_stall stays low
// the input is stalled while the 17 results are sent, longer while out_stall is high
// a result waiting in the output register does not block the next request
// after reset every segment is lit and the first frame is positive phase
module static_lcd_segment_driver_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire slcd_pkg::in_req_t in_req,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output slcd_pkg::out_res_t     out_res
);
  import slcd_pkg::*;

  // command and status between sequencer and datapath
  slcd_cmd_t cmd;
  slcd_sts_t sts;

  // sequencer: idle accepts requests, send walks the 17 frame steps
  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_req.opcode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: segment map, drive phase, position counter, output register
  slcd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

endmodule
`default_nettype wire
